FILE: src/uvss_pkg.sv
`default_nettype none

package uvss_pkg;

  localparam int DEFAULT_DEPTH = 16;

  // Operation codes carried in the func field.
  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_DELETE = 2'd1;
  localparam logic [1:0] FN_SEARCH = 2'd2;

  // Status codes of a result beat.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_BADPOS = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
    logic [4:0]         position;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       found;
    logic [3:0] found_index;
    logic [4:0] count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       scan_init;
    logic       ins_init;
    logic       del_init;
    logic       rd;
    logic       put;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       emit;
    logic [2:0] status;
    logic       found;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] func;
    logic       pos_gt_count;
    logic       pos_ge_count;
    logic       empty;
    logic       full;
    logic       more;
    logic       rd_vld;
    logic       hit;
    logic       out_busy;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/uvss_datapath.sv
`default_nettype none

module uvss_datapath #(
  parameter int DEPTH = uvss_pkg::DEFAULT_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire uvss_pkg::req_t req,
  input  wire logic           rsp_stall,
  input  wire uvss_pkg::cmd_t cmd,
  output uvss_pkg::sts_t      sts,
  output logic                rsp_valid,
  output uvss_pkg::rsp_t      rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 5) ? CW : 5;
  localparam int IW = (AW > 4) ? AW : 4;

  logic [1:0]    func_q;
  logic [31:0]   value_q;
  logic [4:0]    pos_q;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] rem;
  logic          down;
  logic          shifting;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_data;
  logic [AW-1:0] rd_idx;
  logic          rd_vld;
  logic [AW-1:0] hit_idx;

  logic [CW-1:0] pos_c;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] count_x;
  logic [IW-1:0] hit_idx_x;
  logic          hit;
  logic          wb_en;
  logic [AW-1:0] wb_addr;

  assign pos_c     = CW'(pos_q);
  assign pos_x     = XW'(pos_q);
  assign count_x   = XW'(count);
  assign hit_idx_x = IW'(hit_idx);

  assign hit     = rd_vld & ~shifting & (rd_data == value_q);
  // A shift reads one entry ahead and writes it back one place over in the following cycle.
  assign wb_en   = rd_vld & shifting;
  assign wb_addr = down ? (rd_idx + 1'b1) : (rd_idx - 1'b1);

  always_comb begin
    sts.func         = func_q;
    sts.pos_gt_count = pos_x > count_x;
    sts.pos_ge_count = pos_x >= count_x;
    sts.empty        = (count == '0);
    sts.full         = (count == CW'(DEPTH));
    sts.more         = (rem != '0);
    sts.rd_vld       = rd_vld;
    sts.hit          = hit;
    sts.out_busy     = rsp_valid & rsp_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_vld    <= 1'b0;
      shifting  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= cmd.rd;
      if (cmd.scan_init) begin
        shifting <= 1'b0;
      end else if (cmd.ins_init || cmd.del_init) begin
        shifting <= 1'b1;
      end
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= count - 1'b1;
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= req.func;
      value_q <= req.value;
      pos_q   <= req.position;
    end

    if (cmd.scan_init) begin
      idx  <= '0;
      rem  <= count;
      down <= 1'b0;
    end else if (cmd.ins_init) begin
      idx  <= count - 1'b1;
      rem  <= count - pos_c;
      down <= 1'b1;
    end else if (cmd.del_init) begin
      idx  <= pos_c + 1'b1;
      rem  <= count - pos_c - 1'b1;
      down <= 1'b0;
    end else if (cmd.rd) begin
      idx <= down ? (idx - 1'b1) : (idx + 1'b1);
      rem <= rem - 1'b1;
    end

    if (cmd.rd) begin
      rd_data <= mem[idx[AW-1:0]];
      rd_idx  <= idx[AW-1:0];
    end

    if (hit) begin
      hit_idx <= rd_idx;
    end

    if (wb_en) begin
      mem[wb_addr] <= rd_data;
    end else if (cmd.put) begin
      mem[pos_c[AW-1:0]] <= value_q;
    end

    if (cmd.emit) begin
      rsp.status      <= cmd.status;
      rsp.found       <= cmd.found;
      rsp.found_index <= cmd.found ? hit_idx_x[3:0] : 4'd0;
      rsp.count       <= count_x[4:0];
    end
  end

endmodule

`default_nettype wire

FILE: src/uvss_ctrl.sv
`default_nettype none

module uvss_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  input  wire uvss_pkg::sts_t sts,
  output logic                req_stall,
  output uvss_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t     state;
  logic [2:0] res_status;
  logic       res_found;
  logic       scan_end;
  logic       shift_end;

  // A pass is over once no read is left to issue and the last read data is used.
  assign scan_end  = ~sts.hit & ~sts.more & ~sts.rd_vld;
  assign shift_end = ~sts.more & ~sts.rd_vld;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.status = res_status;
    cmd.found  = res_found;
    unique case (state)
      S_IDLE: begin
        cmd.load = req_valid;
      end
      S_CHECK: begin
        unique case (sts.func)
          uvss_pkg::FN_INSERT: cmd.scan_init = ~sts.pos_gt_count;
          uvss_pkg::FN_DELETE: cmd.del_init  = ~sts.empty & ~sts.pos_ge_count;
          uvss_pkg::FN_SEARCH: cmd.scan_init = 1'b1;
          default: ;
        endcase
      end
      S_SCAN: begin
        cmd.rd       = ~sts.hit & sts.more;
        cmd.ins_init = scan_end & (sts.func == uvss_pkg::FN_INSERT) & ~sts.full;
      end
      S_SHIFT: begin
        cmd.rd = sts.more;
        if (shift_end) begin
          if (sts.func == uvss_pkg::FN_INSERT) begin
            cmd.put     = 1'b1;
            cmd.cnt_inc = 1'b1;
          end else begin
            cmd.cnt_dec = 1'b1;
          end
        end
      end
      S_DONE: begin
        cmd.emit = ~sts.out_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= uvss_pkg::ST_OK;
      res_found  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          res_status <= uvss_pkg::ST_OK;
          res_found  <= 1'b0;
          if (req_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          unique case (sts.func)
            uvss_pkg::FN_INSERT: begin
              if (sts.pos_gt_count) begin
                res_status <= uvss_pkg::ST_BADPOS;
                state      <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
            uvss_pkg::FN_DELETE: begin
              if (sts.empty) begin
                res_status <= uvss_pkg::ST_EMPTY;
                state      <= S_DONE;
              end else if (sts.pos_ge_count) begin
                res_status <= uvss_pkg::ST_BADPOS;
                state      <= S_DONE;
              end else begin
                state <= S_SHIFT;
              end
            end
            uvss_pkg::FN_SEARCH: state <= S_SCAN;
            default:             state <= S_DONE;
          endcase
        end
        S_SCAN: begin
          if (sts.hit) begin
            if (sts.func == uvss_pkg::FN_INSERT) begin
              res_status <= uvss_pkg::ST_DUP;
            end else begin
              res_found <= 1'b1;
            end
            state <= S_DONE;
          end else if (scan_end) begin
            if (sts.func != uvss_pkg::FN_INSERT) begin
              state <= S_DONE;
            end else if (sts.full) begin
              res_status <= uvss_pkg::ST_FULL;
              state      <= S_DONE;
            end else begin
              state <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (shift_end) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!sts.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/unique_value_sequence_store.sv
`default_nettype none

// Ordered store of up to DEPTH distinct 32-bit values with insert and delete by
// position and search by value, one request beat in and one result beat out per
// operation. Work runs through a one-read, one-write entry memory with a registered
// read, one entry per cycle. A search scans the stored entries; an insert first
// scans for a duplicate, then shifts the tail up; a delete shifts the tail down;
// and a request rejected on its position or on an empty store goes straight to
// the result. The block is idle again from the edge that raises the result, so
// the next request is taken in the cycle after. A new request is taken while the
// previous result still waits in the output register; the following result then
// waits until that register frees. The entries hold no reset value; only the
// count, the control flags and the controller state are cleared.
module unique_value_sequence_store #(
  parameter int DEPTH = uvss_pkg::DEFAULT_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire uvss_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output uvss_pkg::rsp_t      rsp
);

  uvss_pkg::cmd_t cmd;
  uvss_pkg::sts_t sts;

  uvss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .sts       (sts),
    .req_stall (req_stall),
    .cmd       (cmd)
  );

  uvss_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

FILE: src/uvss_checker.sv
`default_nettype none

module uvss_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire uvss_pkg::req_t req,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire uvss_pkg::rsp_t rsp
);

  // A stalled result beat stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  // Only one operation is in flight: an accepted request closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while an operation was running");

  // A hit is only ever reported with an ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> rsp.status == uvss_pkg::ST_OK)
    else $error("found set on a failed operation");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.found_index == 4'd0)
    else $error("found_index set without a hit");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result beat shown right after reset");

endmodule

bind unique_value_sequence_store uvss_checker u_uvss_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
